FILE: hdl/smv_pkg.sv
package smv_pkg;

  localparam logic [31:0] STUN_MAGIC = 32'h2112A442;
  localparam logic [31:0] FP_XOR     = 32'h5354554E;
  localparam logic [15:0] ATTR_FP    = 16'h8028;
  localparam logic [15:0] ATTR_MI    = 16'h0008;
  localparam logic [16:0] HDR_BYTES  = 17'd20;
  localparam logic [16:0] COUNT_MAX  = 17'h1FFFF;
  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SHORT        = 3'd1,
    ST_UNPADDED     = 3'd2,
    ST_LEN_MISMATCH = 3'd3,
    ST_BAD_COOKIE   = 3'd4,
    ST_OVERRUN      = 3'd5,
    ST_FP_NOT_LAST  = 3'd6,
    ST_BAD_FP       = 3'd7
  } status_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } smv_byte_t;

  typedef struct packed {
    status_t     status;
    logic [1:0]  msg_class;
    logic [11:0] method;
    logic        legacy;
    logic [15:0] msg_len;
    logic        has_mi;
    logic [16:0] mi_off;
    logic        has_fp;
    logic [16:0] fp_off;
  } smv_result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: hdl/smv_in_reg.sv
module smv_in_reg
  import smv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_data,
  input  logic       in_last,
  output logic       in_stall,
  input  logic       go,
  output smv_byte_t  s1
);

  logic       valid_r;
  logic [7:0] data_r;
  logic       last_r;

  assign in_stall = valid_r && !go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      data_r <= in_data;
      last_r <= in_last;
    end
  end

  assign s1 = '{valid: valid_r, data: data_r, last: last_r};

endmodule

FILE: hdl/smv_core.sv
module smv_core
  import smv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  smv_byte_t   s1,
  output logic        res_valid,
  output smv_result_t res
);

  logic [16:0] cnt_r, cnt_nxt;
  logic [15:0] hdr_type_r, hdr_type_nxt;
  logic [15:0] hdr_len_r, hdr_len_nxt;
  logic [31:0] cookie_r, cookie_nxt;
  logic [16:0] nas_r, nas_nxt;
  logic [15:0] at_r, at_nxt;
  logic [15:0] al_r, al_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] crc_fp_r, crc_fp_nxt;
  logic [31:0] rx_fp_r, rx_fp_nxt;
  status_t     err_r, err_nxt;
  logic        has_mi_r, has_mi_nxt;
  logic [16:0] mi_off_r, mi_off_nxt;
  logic        has_fp_r, has_fp_nxt;
  logic [16:0] fp_off_r, fp_off_nxt;

  logic [16:0] size;
  logic [17:0] idx18, nas18, fp18, rel, end_len, end_pad, total;
  logic [16:0] pad;
  logic [15:0] at_v, al_v;
  logic [1:0]  cls;
  logic        cookie_ok;
  status_t     st;
  logic        attrs_ok;

  always_comb begin
    cnt_nxt      = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 17'd1;
    hdr_type_nxt = hdr_type_r;
    hdr_len_nxt  = hdr_len_r;
    cookie_nxt   = cookie_r;
    nas_nxt      = nas_r;
    at_nxt       = at_r;
    al_nxt       = al_r;
    crc_nxt      = crc_byte(crc_r, s1.data);
    crc_fp_nxt   = crc_fp_r;
    rx_fp_nxt    = rx_fp_r;
    err_nxt      = err_r;
    has_mi_nxt   = has_mi_r;
    mi_off_nxt   = mi_off_r;
    has_fp_nxt   = has_fp_r;
    fp_off_nxt   = fp_off_r;

    size    = HDR_BYTES + {1'b0, hdr_len_r};
    idx18   = {1'b0, cnt_r};
    nas18   = {1'b0, nas_r};
    fp18    = {1'b0, fp_off_r};
    rel     = idx18 - nas18;
    at_v    = at_r;
    al_v    = al_r;
    pad     = 17'({1'b0, al_r} + 17'd3) & ~17'd3;
    end_len = nas18 + 18'd4;
    end_pad = nas18 + 18'd4;

    if (cnt_r < 17'd2) begin
      hdr_type_nxt = {hdr_type_r[7:0], s1.data};
    end else if (cnt_r < 17'd4) begin
      hdr_len_nxt = {hdr_len_r[7:0], s1.data};
    end else if (cnt_r < 17'd8) begin
      cookie_nxt = {cookie_r[23:0], s1.data};
    end else if (cnt_r >= HDR_BYTES && cnt_r < size && err_r == ST_OK) begin
      if (cnt_r == nas_r) begin
        crc_fp_nxt = crc_r;
        at_v = '0;
        al_v = '0;
      end
      if (idx18 >= nas18 && idx18 < nas18 + 18'd4) begin
        if (rel[1] == 1'b0) begin
          at_v = {at_v[7:0], s1.data};
        end else begin
          al_v = {al_v[7:0], s1.data};
        end
        at_nxt = at_v;
        al_nxt = al_v;
        if (rel[1:0] == 2'd3) begin
          pad     = 17'({1'b0, al_v} + 17'd3) & ~17'd3;
          end_len = nas18 + 18'd4 + {2'b0, al_v};
          end_pad = nas18 + 18'd4 + {1'b0, pad};
          if (end_len > {1'b0, size}) begin
            err_nxt = ST_OVERRUN;
          end else begin
            if (at_v == ATTR_FP) begin
              has_fp_nxt = 1'b1;
              fp_off_nxt = nas_r;
              if (end_pad < {1'b0, size}) begin
                err_nxt = ST_FP_NOT_LAST;
              end
            end else if (at_v == ATTR_MI) begin
              has_mi_nxt = 1'b1;
              mi_off_nxt = nas_r;
            end
            nas_nxt = end_pad[16:0];
          end
        end
      end else if (has_fp_r && idx18 >= fp18 + 18'd4 && idx18 < fp18 + 18'd8) begin
        rx_fp_nxt = {rx_fp_r[23:0], s1.data};
      end
    end
  end

  always_comb begin
    total     = idx18 + 18'd1;
    cls       = {hdr_type_nxt[8], hdr_type_nxt[4]};
    cookie_ok = (cookie_nxt == STUN_MAGIC);
    if (total < {1'b0, HDR_BYTES}) begin
      st = ST_SHORT;
    end else if (hdr_len_nxt[1:0] != 2'd0) begin
      st = ST_UNPADDED;
    end else if ({2'b0, hdr_len_nxt} != total - {1'b0, HDR_BYTES}) begin
      st = ST_LEN_MISMATCH;
    end else if (cls != 2'd0 && !cookie_ok) begin
      st = ST_BAD_COOKIE;
    end else if (err_nxt != ST_OK) begin
      st = err_nxt;
    end else if (has_fp_nxt && ((~crc_fp_nxt ^ FP_XOR) != rx_fp_nxt)) begin
      st = ST_BAD_FP;
    end else begin
      st = ST_OK;
    end
    attrs_ok = (st == ST_OK) || (st == ST_OVERRUN) || (st == ST_FP_NOT_LAST)
               || (st == ST_BAD_FP);

    res        = '0;
    res.status = st;
    if (st != ST_SHORT) begin
      res.msg_class = cls;
      res.method    = {hdr_type_nxt[13:9], hdr_type_nxt[7:5], hdr_type_nxt[3:0]};
      res.legacy    = (cls == 2'd0) && !cookie_ok;
      res.msg_len   = hdr_len_nxt;
    end
    if (attrs_ok && has_mi_nxt) begin
      res.has_mi = 1'b1;
      res.mi_off = mi_off_nxt;
    end
    if (attrs_ok && has_fp_nxt) begin
      res.has_fp = 1'b1;
      res.fp_off = fp_off_nxt;
    end
  end

  assign res_valid = go && s1.last;

  always_ff @(posedge clk) begin
    if (!rst_n || res_valid) begin
      cnt_r      <= '0;
      hdr_type_r <= '0;
      hdr_len_r  <= '0;
      cookie_r   <= '0;
      nas_r      <= HDR_BYTES;
      at_r       <= '0;
      al_r       <= '0;
      crc_r      <= CRC_INIT;
      crc_fp_r   <= '0;
      rx_fp_r    <= '0;
      err_r      <= ST_OK;
      has_mi_r   <= 1'b0;
      mi_off_r   <= '0;
      has_fp_r   <= 1'b0;
      fp_off_r   <= '0;
    end else if (go) begin
      cnt_r      <= cnt_nxt;
      hdr_type_r <= hdr_type_nxt;
      hdr_len_r  <= hdr_len_nxt;
      cookie_r   <= cookie_nxt;
      nas_r      <= nas_nxt;
      at_r       <= at_nxt;
      al_r       <= al_nxt;
      crc_r      <= crc_nxt;
      crc_fp_r   <= crc_fp_nxt;
      rx_fp_r    <= rx_fp_nxt;
      err_r      <= err_nxt;
      has_mi_r   <= has_mi_nxt;
      mi_off_r   <= mi_off_nxt;
      has_fp_r   <= has_fp_nxt;
      fp_off_r   <= fp_off_nxt;
    end
  end

endmodule

FILE: hdl/smv_out_reg.sv
module smv_out_reg
  import smv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_valid,
  input  smv_result_t res,
  input  logic        out_stall,
  output logic        out_valid,
  output smv_result_t out_res,
  output logic        free
);

  logic        valid_r, valid_nxt;
  smv_result_t res_r;

  assign free = !valid_r || !out_stall;

  always_comb begin
    if (res_valid) begin
      valid_nxt = 1'b1;
    end else if (out_stall) begin
      valid_nxt = valid_r;
    end else begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

FILE: hdl/stun_message_validator.sv
// A verdict is registered in the output stage when the parser takes its datagram's last byte from the input register.
// Throughput: one byte per cycle; a final byte waits only while a verdict is stalled.
// The byte-wide CRC-32 and header/attribute counters set the one-byte-per-cycle rate.
// Reset: rst_n low at a rising edge clears all control and parser state; the next
// byte starts a new datagram.
module stun_message_validator
  import smv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [1:0]  out_msg_class,
  output logic [11:0] out_method,
  output logic        out_legacy_format,
  output logic [15:0] out_message_length,
  output logic        out_has_integrity,
  output logic [16:0] out_integrity_offset,
  output logic        out_has_fingerprint,
  output logic [16:0] out_fingerprint_offset
);

  smv_byte_t   s1;
  smv_result_t res;
  smv_result_t out_res;
  logic        go;
  logic        res_valid;
  logic        free;

  assign go = s1.valid && (!s1.last || free);

  smv_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data_byte),
    .in_last  (in_last_byte),
    .in_stall (in_stall),
    .go       (go),
    .s1       (s1)
  );

  smv_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .s1        (s1),
    .res_valid (res_valid),
    .res       (res)
  );

  smv_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .free      (free)
  );

  assign out_status             = out_res.status;
  assign out_msg_class          = out_res.msg_class;
  assign out_method             = out_res.method;
  assign out_legacy_format      = out_res.legacy;
  assign out_message_length     = out_res.msg_len;
  assign out_has_integrity      = out_res.has_mi;
  assign out_integrity_offset   = out_res.mi_off;
  assign out_has_fingerprint    = out_res.has_fp;
  assign out_fingerprint_offset = out_res.fp_off;

endmodule

FILE: verif/tb_stun_message_validator.sv
`timescale 1ns / 100ps

module tb_stun_message_validator;
  import smv_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  logic        clk;
  logic        rst_n                  = 1'b0;
  logic        in_valid               = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte           = 8'h00;
  logic        in_last_byte           = 1'b0;
  logic        out_valid;
  logic        out_stall              = 1'b0;
  logic [2:0]  out_status;
  logic [1:0]  out_msg_class;
  logic [11:0] out_method;
  logic        out_legacy_format;
  logic [15:0] out_message_length;
  logic        out_has_integrity;
  logic [16:0] out_integrity_offset;
  logic        out_has_fingerprint;
  logic [16:0] out_fingerprint_offset;

  stun_message_validator DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_data_byte           (in_data_byte),
    .in_last_byte           (in_last_byte),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_msg_class          (out_msg_class),
    .out_method             (out_method),
    .out_legacy_format      (out_legacy_format),
    .out_message_length     (out_message_length),
    .out_has_integrity      (out_has_integrity),
    .out_integrity_offset   (out_integrity_offset),
    .out_has_fingerprint    (out_has_fingerprint),
    .out_fingerprint_offset (out_fingerprint_offset)
  );

  smv_result_t verdict_q[$];
  logic [7:0]  dgram[$];
  int          fail_count  = 0;
  int          quiet_cycles = 0;
  int unsigned bytes_sent  = 0;
  bit          no_idle     = 1'b0;

  // parser state of the predictor
  logic [16:0] p_count;
  logic [15:0] p_type;
  logic [15:0] p_len;
  logic [31:0] p_cookie;
  logic [16:0] p_next_attr;
  logic [15:0] p_attr_type;
  logic [15:0] p_attr_len;
  logic [31:0] p_crc;
  logic [31:0] p_crc_at_fp;
  logic [31:0] p_fp_value;
  status_t     p_err;
  logic        p_seen_mi;
  logic        p_seen_fp;
  logic [16:0] p_mi_off;
  logic [16:0] p_fp_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99, 0) < 19);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_stun_message_validator NOT OK");
      $finish;
    end
  end

  function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic void clear_parser();
    p_count     = '0;
    p_type      = '0;
    p_len       = '0;
    p_cookie    = '0;
    p_next_attr = HDR_BYTES;
    p_attr_type = '0;
    p_attr_len  = '0;
    p_crc       = CRC_INIT;
    p_crc_at_fp = '0;
    p_fp_value  = '0;
    p_err       = ST_OK;
    p_seen_mi   = 1'b0;
    p_seen_fp   = 1'b0;
    p_mi_off    = '0;
    p_fp_off    = '0;
  endfunction

  function automatic void walk_attr_byte(input int unsigned idx, input logic [7:0] b);
    int unsigned msg_end;
    int unsigned nas;
    int unsigned padded;
    msg_end = {15'd0, HDR_BYTES + {1'b0, p_len}};
    nas     = {15'd0, p_next_attr};
    if (idx < HDR_BYTES || idx >= msg_end || p_err != ST_OK) return;
    if (idx == nas) begin
      p_crc_at_fp = p_crc;
      p_attr_type = '0;
      p_attr_len  = '0;
    end
    if (idx >= nas && idx < nas + 4) begin
      if (idx < nas + 2) begin
        p_attr_type = {p_attr_type[7:0], b};
      end else begin
        p_attr_len = {p_attr_len[7:0], b};
      end
      if (idx == nas + 3) begin
        padded = (p_attr_len + 3) / 4 * 4;
        if (nas + 4 + p_attr_len > msg_end) begin
          p_err = ST_OVERRUN;
          return;
        end
        if (p_attr_type == ATTR_FP) begin
          p_seen_fp = 1'b1;
          p_fp_off  = nas[16:0];
          if (nas + 4 + padded < msg_end) p_err = ST_FP_NOT_LAST;
        end else if (p_attr_type == ATTR_MI) begin
          p_seen_mi = 1'b1;
          p_mi_off  = nas[16:0];
        end
        p_next_attr = 17'(nas + 4 + padded);
      end
      return;
    end
    if (p_seen_fp && idx >= p_fp_off + 4 && idx < p_fp_off + 8) begin
      p_fp_value = {p_fp_value[23:0], b};
    end
  endfunction

  function automatic bit predict_verdict(input logic [7:0] b, input logic l,
                                         output smv_result_t r);
    int unsigned idx;
    int unsigned total;
    logic [1:0]  cls;
    logic [11:0] meth;
    logic        cookie_ok;
    status_t     st;
    idx = {15'd0, p_count};
    if (idx < 2) begin
      p_type = {p_type[7:0], b};
    end else if (idx < 4) begin
      p_len = {p_len[7:0], b};
    end else if (idx < 8) begin
      p_cookie = {p_cookie[23:0], b};
    end else begin
      walk_attr_byte(idx, b);
    end
    p_crc = crc32_update(p_crc, b);
    if (p_count != COUNT_MAX) p_count = p_count + 17'd1;
    r = '0;
    if (!l) return 1'b0;

    total     = idx + 1;
    cls       = {p_type[8], p_type[4]};
    meth      = {p_type[13:9], p_type[7:5], p_type[3:0]};
    cookie_ok = (p_cookie == STUN_MAGIC);
    if (total < HDR_BYTES) begin
      st = ST_SHORT;
    end else if (p_len[1:0] != 2'b00) begin
      st = ST_UNPADDED;
    end else if (p_len != total - HDR_BYTES) begin
      st = ST_LEN_MISMATCH;
    end else if (cls != 2'd0 && !cookie_ok) begin
      st = ST_BAD_COOKIE;
    end else if (p_err != ST_OK) begin
      st = p_err;
    end else if (p_seen_fp && ((~p_crc_at_fp ^ FP_XOR) != p_fp_value)) begin
      st = ST_BAD_FP;
    end else begin
      st = ST_OK;
    end

    r.status = st;
    if (st != ST_SHORT) begin
      r.msg_class = cls;
      r.method    = meth;
      r.legacy    = (cls == 2'd0) && !cookie_ok;
      r.msg_len   = p_len;
    end
    if (st == ST_OK || st >= ST_OVERRUN) begin
      if (p_seen_mi) begin
        r.has_mi = 1'b1;
        r.mi_off = p_mi_off;
      end
      if (p_seen_fp) begin
        r.has_fp = 1'b1;
        r.fp_off = p_fp_off;
      end
    end
    clear_parser();
    return 1'b1;
  endfunction

  function automatic void compare_field(input string name, input logic [16:0] exp_v,
                                        input logic [16:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : check_verdicts
    smv_result_t exp_v;
    if (out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: verdict with none expected, expected nothing, got status %0d",
                 $time, out_status);
        fail_count++;
      end else begin
        exp_v = verdict_q.pop_front();
        compare_field("status", exp_v.status, out_status);
        compare_field("msg_class", exp_v.msg_class, out_msg_class);
        compare_field("method", exp_v.method, out_method);
        compare_field("legacy_format", exp_v.legacy, out_legacy_format);
        compare_field("message_length", exp_v.msg_len, out_message_length);
        compare_field("has_integrity", exp_v.has_mi, out_has_integrity);
        compare_field("integrity_offset", exp_v.mi_off, out_integrity_offset);
        compare_field("has_fingerprint", exp_v.has_fp, out_has_fingerprint);
        compare_field("fingerprint_offset", exp_v.fp_off, out_fingerprint_offset);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    smv_result_t res;
    if (!no_idle && $urandom_range(99, 0) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (predict_verdict(b, l, res)) verdict_q.push_back(res);
  endtask

  task automatic send_dgram();
    for (int i = 0; i < dgram.size(); i++) begin
      send_byte(dgram[i], i == dgram.size() - 1);
    end
  endtask

  task automatic wait_for_verdicts();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
  endtask

  function automatic void push_rand();
    dgram.push_back(8'($urandom));
  endfunction

  function automatic void push16(input logic [15:0] v);
    dgram.push_back(v[15:8]);
    dgram.push_back(v[7:0]);
  endfunction

  function automatic void push32(input logic [31:0] v);
    push16(v[31:16]);
    push16(v[15:0]);
  endfunction

  function automatic void pad4();
    while (dgram.size() % 4 != 0) push_rand();
  endfunction

  function automatic void begin_msg(input logic [15:0] mtype, input logic [31:0] cookie);
    dgram.delete();
    push16(mtype);
    push16(16'h0000);
    push32(cookie);
    repeat (12) push_rand();
  endfunction

  function automatic void set_length();
    logic [15:0] len;
    len = 16'(dgram.size() - 20);
    dgram[2] = len[15:8];
    dgram[3] = len[7:0];
  endfunction

  function automatic void add_attr(input logic [15:0] atype, input int unsigned alen);
    push16(atype);
    push16(alen[15:0]);
    repeat (alen) push_rand();
    pad4();
  endfunction

  // seal the length first: the checksum covers the header length field
  function automatic void add_fingerprint(input bit good, input int unsigned tail);
    logic [15:0] len;
    logic [31:0] crc;
    logic [31:0] fp;
    len = 16'(dgram.size() - 20 + 8 + (tail + 3) / 4 * 4);
    dgram[2] = len[15:8];
    dgram[3] = len[7:0];
    crc = CRC_INIT;
    foreach (dgram[i]) crc = crc32_update(crc, dgram[i]);
    fp = ~crc ^ FP_XOR;
    if (!good) fp = fp ^ (32'd1 << $urandom_range(31, 0));
    push16(ATTR_FP);
    push16(16'(4 + tail));
    push32(fp);
    repeat (tail) push_rand();
    pad4();
  endfunction

  task automatic test_short_datagrams();
    dgram.delete();
    push_rand();
    send_dgram();
    dgram.delete();
    repeat (19) dgram.push_back(8'hFF);
    send_dgram();
    dgram.delete();
    repeat (2) dgram.push_back(8'h00);
    send_dgram();
  endtask

  task automatic test_header_checks();
    dgram.delete();
    repeat (20) dgram.push_back(8'h00);
    send_dgram();
    dgram.delete();
    repeat (20) dgram.push_back(8'hFF);
    send_dgram();
    begin_msg(16'h0001, STUN_MAGIC);
    dgram[3] = 8'd6;
    send_dgram();
    begin_msg(16'h0101, STUN_MAGIC);
    dgram[3] = 8'd8;
    send_dgram();
    begin_msg(16'h0111, 32'hDEADBEEF);
    send_dgram();
    begin_msg(16'h0011, 32'h00000000);
    send_dgram();
    begin_msg(16'hC001, 32'h12345678);
    add_attr(16'h0006, 3);
    set_length();
    send_dgram();
    begin_msg(16'h3EEF, STUN_MAGIC);
    send_dgram();
  endtask

  task automatic test_attribute_walk();
    begin_msg(16'h0001, STUN_MAGIC);
    add_attr(16'h0006, 5);
    add_attr(ATTR_MI, 20);
    add_fingerprint(1'b1, 0);
    send_dgram();
    begin_msg(16'h0101, STUN_MAGIC);
    add_attr(16'h8022, 3);
    add_fingerprint(1'b0, 0);
    send_dgram();
    begin_msg(16'h0001, STUN_MAGIC);
    add_fingerprint(1'b1, 3);
    send_dgram();
    begin_msg(16'h0001, STUN_MAGIC);
    add_fingerprint(1'b1, 0);
    add_attr(16'h0006, 4);
    set_length();
    send_dgram();
    begin_msg(16'h0001, STUN_MAGIC);
    add_fingerprint(1'b1, 0);
    add_fingerprint(1'b1, 0);
    send_dgram();
    begin_msg(16'h0001, STUN_MAGIC);
    add_attr(ATTR_MI, 20);
    push16(16'h0006);
    push16(16'd12);
    repeat (4) push_rand();
    set_length();
    send_dgram();
    begin_msg(16'h0101, 32'h00000000);
    push16(16'h0006);
    push16(16'd12);
    repeat (4) push_rand();
    set_length();
    send_dgram();
    begin_msg(16'h0001, STUN_MAGIC);
    push16(ATTR_FP);
    push16(16'd0);
    set_length();
    send_dgram();
    begin_msg(16'h0111, STUN_MAGIC);
    add_attr(16'h0024, 0);
    add_attr(ATTR_MI, 20);
    set_length();
    send_dgram();
  endtask

  function automatic void build_random_dgram();
    int unsigned kind;
    int unsigned pick;
    int unsigned idx;
    logic [15:0] atype;
    logic [31:0] cookie;
    kind = $urandom_range(99, 0);
    if (kind < 12) begin
      dgram.delete();
      repeat ($urandom_range(40, 1)) push_rand();
      return;
    end
    cookie = ($urandom_range(99, 0) < 15) ? $urandom : STUN_MAGIC;
    begin_msg(16'($urandom), cookie);
    repeat ($urandom_range(3, 0)) begin
      pick  = $urandom_range(99, 0);
      atype = 16'($urandom);
      if (pick < 25) begin
        atype = ATTR_MI;
      end else if (pick < 32) begin
        atype = ATTR_FP;
      end
      add_attr(atype, (atype == ATTR_MI && pick < 20) ? 20 : $urandom_range(12, 0));
    end
    if ($urandom_range(99, 0) < 60) begin
      add_fingerprint($urandom_range(99, 0) >= 10,
                      ($urandom_range(99, 0) < 80) ? 0 : $urandom_range(4, 1));
    end else begin
      set_length();
    end
    if (kind >= 88) begin
      case ($urandom_range(3, 0))
        0: begin
          idx = $urandom_range(dgram.size() - 1, 0);
          dgram[idx] = dgram[idx] ^ (8'd1 << $urandom_range(7, 0));
        end
        1: begin
          idx = $urandom_range(dgram.size() - 1, 1);
          while (dgram.size() > idx) void'(dgram.pop_back());
        end
        2: begin
          repeat ($urandom_range(8, 1)) push_rand();
        end
        default: begin
          idx = $urandom_range(3, 2);
          dgram[idx] = dgram[idx] ^ (8'd1 << $urandom_range(7, 0));
        end
      endcase
    end
  endfunction

  task automatic test_random_traffic();
    int unsigned n_dgram;
    n_dgram = 0;
    while (bytes_sent < 650 || n_dgram < 3) begin
      build_random_dgram();
      send_dgram();
      n_dgram++;
      if (n_dgram % 2 == 0) wait_for_verdicts();
    end
  endtask

  task automatic finish_run();
    wait_for_verdicts();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_stun_message_validator OK");
    end else begin
      $display("tb_stun_message_validator NOT OK");
    end
    $finish;
  endtask

  initial begin
    clear_parser();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_datagrams();
    test_header_checks();
    no_idle = 1'b1;
    test_attribute_walk();
    no_idle = 1'b0;
    wait_for_verdicts();
    test_random_traffic();
    finish_run();
  end

endmodule
